>>> hdl/dpfn_pkg.sv
// Shared types and constants for the dining-philosopher fork node.
package dpfn_pkg;

    localparam int MAX_EDGES_DEF = 8;
    localparam int EDGE_W        = 3;
    localparam int PHASE_W       = 2;
    localparam int EC_W          = 4;
    localparam int MASK_W        = 8;
    localparam int CFG_DATA_W    = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int OP_W          = 2;

    typedef enum logic [PHASE_W-1:0] {
        PH_START  = 2'd0,
        PH_EAT    = 2'd1,
        PH_THINK  = 2'd2,
        PH_HUNGRY = 2'd3
    } t_phase;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_TOKEN = 2'd1,
        OP_FORK  = 2'd2
    } t_op;

    typedef enum logic {
        MSG_REQ  = 1'b0,
        MSG_FORK = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EDGE_COUNT = 1'b0,
        CFG_FORK_MASK  = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    typedef struct packed {
        logic busy;
        logic hit;
        logic last;
    } t_scan_stat;

endpackage

>>> hdl/dining_philosopher_fork_node_unit.sv
// Top level of the dining-philosopher fork node: flags, sequencer and output register.
//
// One node of the hygienic dining-philosophers protocol. Input items arrive on the
// slave stream: tuser carries the operation (tick, request token arrives, clean fork
// arrives), tdata the edge of an arrival. Each item yields one or more result items
// on the master stream: one per outgoing message (request token or dirty fork) in
// ascending edge order, or a single status item when nothing is sent; tlast marks
// the final result of an input item.
// Arrivals and ticks that send nothing leave their status item in the output
// register the cycle after acceptance. A tick that sends messages hands its
// mask to the edge scanner, which tests one edge per cycle but holds on a set
// edge while the receiver stalls, and the node is not ready during the scan.
// Configuration (edge count, initial fork mask) must be written by the user through
// the plain write port only while the block is idle; the block does not enforce it.
// Reset clears the phase to not started, forks held and tokens to zero and marks
// every fork dirty; edge count returns to 2 and the fork mask to zero.
// When the receiver stalls, the output register holds its item, the scan waits on
// the pending edge, and no new input item is accepted until the register frees.
module dining_philosopher_fork_node_unit #(
    parameter int MAX_EDGES = dpfn_pkg::MAX_EDGES_DEF,
    localparam int IDX_W    = $clog2(MAX_EDGES)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [dpfn_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [dpfn_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // input items
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [7:0]                       i_s_tdata,  // [2:0] edge_req, rest zero
    input  logic [1:0]                       i_s_tuser,  // [1:0] operation
    // result items
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [7:0]                       o_m_tdata,  // [2:0] target_edge, [4:3] phase
    output logic [1:0]                       o_m_tuser,  // [0] message_valid, [1] message_kind
    output logic                             o_m_tlast
);

    // configuration registers
    logic [dpfn_pkg::EC_W-1:0]   r_edge_count;
    logic [dpfn_pkg::MASK_W-1:0] r_fork_mask;

    // protocol flags
    dpfn_pkg::t_phase       r_phase, n_phase;
    logic [MAX_EDGES-1:0]   r_forks_held, n_forks_held;
    logic [MAX_EDGES-1:0]   r_forks_dirty, n_forks_dirty;
    logic [MAX_EDGES-1:0]   r_tokens_held, n_tokens_held;
    dpfn_pkg::t_kind        r_kind, n_kind;

    dpfn_pkg::t_state       r_state, n_state;

    // output register
    logic                   r_o_valid;
    logic                   r_o_msg;
    dpfn_pkg::t_kind        r_o_kind;
    logic [dpfn_pkg::EDGE_W-1:0] r_o_edge;
    dpfn_pkg::t_phase       r_o_phase;
    logic                   r_o_last;

    logic [MAX_EDGES-1:0]   w_act;
    logic [MAX_EDGES-1:0]   w_bit;
    logic [MAX_EDGES-1:0]   w_init;
    logic [MAX_EDGES-1:0]   w_scan_mask;
    logic                   w_out_free;
    logic                   w_accept;
    logic                   w_load;
    logic                   w_emit;
    dpfn_pkg::t_op          w_op;
    dpfn_pkg::t_scan_stat   w_scan;
    logic [IDX_W-1:0]       w_idx;

    // edges in use; a count above MAX_EDGES simply covers every edge
    always_comb begin
        for (int e = 0; e < MAX_EDGES; e++) begin
            w_act[e] = (int'(r_edge_count) > e);
            w_bit[e] = (int'(i_s_tdata[dpfn_pkg::EDGE_W-1:0]) == e);
        end
        w_init = MAX_EDGES'({{MAX_EDGES{1'b0}}, r_fork_mask});
    end

    assign w_out_free = !r_o_valid || i_m_tready;
    assign w_op       = dpfn_pkg::t_op'(i_s_tuser);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dpfn_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        w_accept   = 1'b0;
        w_load     = 1'b0;
        w_emit     = 1'b0;
        case (r_state)
            dpfn_pkg::S_IDLE: begin
                o_s_tready = w_out_free;
                w_accept   = i_s_tvalid && w_out_free;
                if (w_accept && (w_scan_mask != '0)) begin
                    w_load  = 1'b1;
                    n_state = dpfn_pkg::S_SCAN;
                end
            end
            dpfn_pkg::S_SCAN: begin
                w_emit = w_scan.hit && w_out_free;
                if (w_emit && w_scan.last) begin
                    n_state = dpfn_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dpfn_pkg::S_IDLE;
            end
        endcase
    end

    // flag update for one input item, all edges in parallel
    always_comb begin
        logic [MAX_EDGES-1:0] v_req;
        logic [MAX_EDGES-1:0] v_snd;
        n_phase       = r_phase;
        n_forks_held  = r_forks_held;
        n_forks_dirty = r_forks_dirty;
        n_tokens_held = r_tokens_held;
        n_kind        = r_kind;
        v_req         = '0;
        v_snd         = '0;
        case (w_op)
            dpfn_pkg::OP_TOKEN: begin
                n_tokens_held = r_tokens_held | (w_bit & w_act);
            end
            dpfn_pkg::OP_FORK: begin
                n_forks_held  = r_forks_held | (w_bit & w_act);
                n_forks_dirty = r_forks_dirty & ~(w_bit & w_act);
            end
            dpfn_pkg::OP_TICK: begin
                case (r_phase)
                    dpfn_pkg::PH_START: begin
                        n_forks_dirty = '1;
                        n_forks_held  = w_init & w_act;
                        n_tokens_held = w_act & ~w_init;
                        n_phase       = dpfn_pkg::PH_THINK;
                    end
                    dpfn_pkg::PH_THINK: begin
                        n_phase = dpfn_pkg::PH_HUNGRY;
                    end
                    dpfn_pkg::PH_HUNGRY: begin
                        if ((r_forks_held & w_act) == w_act) begin
                            n_phase       = dpfn_pkg::PH_EAT;
                            n_forks_dirty = r_forks_dirty | w_act;
                        end
                    end
                    default: begin
                        n_phase = dpfn_pkg::PH_THINK;
                    end
                endcase
                // hungry: ask for every missing fork whose token is here
                if (n_phase == dpfn_pkg::PH_HUNGRY) begin
                    v_req         = n_tokens_held & ~n_forks_held & w_act;
                    n_tokens_held = n_tokens_held & ~v_req;
                end
                // nothing requested and not eating: hand over requested dirty forks
                if ((v_req == '0) && (n_phase != dpfn_pkg::PH_EAT)) begin
                    v_snd         = n_tokens_held & n_forks_held & n_forks_dirty & w_act;
                    n_forks_held  = n_forks_held & ~v_snd;
                    n_forks_dirty = n_forks_dirty & ~v_snd;
                end
                n_kind = (v_req != '0) ? dpfn_pkg::MSG_REQ : dpfn_pkg::MSG_FORK;
            end
            default: begin
            end
        endcase
        w_scan_mask = (v_req != '0) ? v_req : v_snd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count  <= dpfn_pkg::EC_W'(2);
            r_fork_mask   <= '0;
            r_phase       <= dpfn_pkg::PH_START;
            r_forks_held  <= '0;
            r_forks_dirty <= '1;
            r_tokens_held <= '0;
            r_kind        <= dpfn_pkg::MSG_REQ;
        end else begin
            if (i_cfg_we) begin
                case (dpfn_pkg::t_cfg_reg'(i_cfg_addr))
                    dpfn_pkg::CFG_EDGE_COUNT: begin
                        r_edge_count <= i_cfg_wdata[dpfn_pkg::EC_W-1:0];
                    end
                    dpfn_pkg::CFG_FORK_MASK: begin
                        r_fork_mask <= i_cfg_wdata[dpfn_pkg::MASK_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_phase       <= n_phase;
                r_forks_held  <= n_forks_held;
                r_forks_dirty <= n_forks_dirty;
                r_tokens_held <= n_tokens_held;
                r_kind        <= n_kind;
            end
        end
    end

    dpfn_edge_scan #(
        .MAX_EDGES (MAX_EDGES)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_mask  (w_scan_mask),
        .i_step  (w_out_free),
        .o_stat  (w_scan),
        .o_idx   (w_idx)
    );

    // output register: status item on a quiet accept, one message per scan hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_accept && (w_scan_mask == '0)) begin
            r_o_valid <= 1'b1;
        end else if (w_emit) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (w_scan_mask == '0)) begin
            r_o_msg   <= 1'b0;
            r_o_kind  <= dpfn_pkg::MSG_REQ;
            r_o_edge  <= '0;
            r_o_phase <= n_phase;
            r_o_last  <= 1'b1;
        end else if (w_emit) begin
            r_o_msg   <= 1'b1;
            r_o_kind  <= r_kind;
            r_o_edge  <= dpfn_pkg::EDGE_W'(w_idx);
            r_o_phase <= r_phase;
            r_o_last  <= w_scan.last;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {3'b000, r_o_phase, r_o_edge};
    assign o_m_tuser  = {r_o_kind, r_o_msg};
    assign o_m_tlast  = r_o_last;

    // the final message of a scan returns the sequencer to idle
    a_scan_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_scan.last) |=> (r_state == dpfn_pkg::S_IDLE))
        else $error("sequencer did not return to idle after last message");

    // while scanning, the scanner still has edges pending
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dpfn_pkg::S_SCAN) |-> w_scan.busy)
        else $error("scan state with empty message mask");

    // a status item always closes its input item
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> o_m_tlast)
        else $error("status item without last marker");

endmodule

>>> hdl/dpfn_edge_scan.sv
// Edge scanner: walks a message mask and reports set bits, one edge per cycle unless stalled.
module dpfn_edge_scan #(
    parameter int MAX_EDGES = dpfn_pkg::MAX_EDGES_DEF,
    localparam int IDX_W    = $clog2(MAX_EDGES)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [MAX_EDGES-1:0]  i_mask,
    input  logic                  i_step,
    output dpfn_pkg::t_scan_stat  o_stat,
    output logic [IDX_W-1:0]      o_idx
);

    logic [MAX_EDGES-1:0] r_mask;
    logic [IDX_W-1:0]     r_idx;
    logic [MAX_EDGES-1:0] w_onehot;
    logic                 w_bit;

    always_comb begin
        w_onehot    = MAX_EDGES'(1) << r_idx;
        w_bit       = r_mask[r_idx];
        o_stat.busy = |r_mask;
        o_stat.hit  = o_stat.busy && w_bit;
        o_stat.last = ((r_mask & ~w_onehot) == '0);
        o_idx       = r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_mask <= i_mask;
            r_idx  <= '0;
        end else if (o_stat.busy) begin
            if (!w_bit) begin
                // skip an edge with nothing to send
                r_idx <= IDX_W'(r_idx + 1'b1);
            end else if (i_step) begin
                r_mask <= r_mask & ~w_onehot;
                r_idx  <= IDX_W'(r_idx + 1'b1);
            end
        end
    end

endmodule
